@@ rtl/checksum_frame_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// Checksum frame receiver assertion macros
// Shared concurrent assertion wrappers for the RTL files.
// ----------------------------------------------------------------------------
`ifndef CHECKSUM_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUM_FRAME_RECEIVER_DEFINES_SVH

// Generic form: explicit clock and active-low reset.
`define CFR_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Common form: uses the clk_i / rst_ni ports of the enclosing module.
`define CFR_ASSERT(lbl, prop, msg) \
  `CFR_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the checksum frame receiver modules.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int MAX_FRAME_BYTES = 4;
  localparam int POS_W           = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;

  localparam logic [7:0]  HEADER_RESET  = 8'h98;
  localparam logic [15:0] TIMEOUT_RESET = 16'd15;
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;

  // command field codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  typedef logic [MAX_FRAME_BYTES-1:0][7:0] payload_t;

  // frame completion status from the parser
  typedef struct packed {
    logic ok;
    logic bad;
  } commit_t;

endpackage

@@ rtl/checksum_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// checksum_frame_receiver
// Byte-stream frame receiver: a header byte, FRAME_BYTES payload bytes and a
// mod-256 sum byte. A good frame becomes the held data and clears the age
// counter; millisecond ticks age the held data until it times out and reads
// as zero with data_valid low. Each input transaction yields one result
// transaction carrying the held data and the frame_ok / frame_bad pulses.
// Throughput is one transaction per clock: the parser and age logic update in
// the accepting cycle and the result is registered, so it is offered on the
// next cycle. A new input is taken whenever the result register is empty or
// is being drained in the same cycle.
// ----------------------------------------------------------------------------
`include "checksum_frame_receiver_defines.svh"

module checksum_frame_receiver
  import cfr_pkg::*;
#(
  parameter int FRAME_BYTES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            data0_o,
  output logic [7:0]            data1_o,
  output logic [7:0]            data2_o,
  output logic [7:0]            data3_o,
  output logic                  data_valid_o,
  output logic                  frame_ok_o,
  output logic                  frame_bad_o
);

  logic [7:0]  header_q;
  logic [15:0] timeout_q;
  logic        step;
  commit_t     commit;
  commit_t     status_q;
  payload_t    pending;
  payload_t    held;
  logic        held_valid;
  logic        out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= HEADER_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER:  header_q  <= cfg_wdata_i[7:0];
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i[15:0];
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  cfr_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .command_i (command_i),
    .rx_byte_i (rx_byte_i),
    .header_i  (header_q),
    .commit_o  (commit),
    .pending_o (pending)
  );

  cfr_holder #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_holder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .command_i (command_i),
    .commit_i  (commit),
    .pending_i (pending),
    .timeout_i (timeout_q),
    .held_o    (held),
    .valid_o   (held_valid)
  );

  // result register; held data is stable while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= '0;
    end else if (step) begin
      out_valid_q <= 1'b1;
      status_q    <= commit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data0_o      = held[0];
  assign data1_o      = held[1];
  assign data2_o      = held[2];
  assign data3_o      = held[3];
  assign data_valid_o = held_valid;
  assign frame_ok_o   = status_q.ok;
  assign frame_bad_o  = status_q.bad;

  `CFR_ASSERT(a_pulse_excl, !(status_q.ok && status_q.bad),
              "top: frame_ok and frame_bad together")
  `CFR_ASSERT(a_ok_valid, (out_valid_q && status_q.ok) |-> held_valid,
              "top: good frame reported without valid data")
  `CFR_ASSERT(a_ready_free, !out_valid_q |-> in_ready_o,
              "top: input stalled with empty result register")

endmodule

@@ rtl/cfr_parser.sv @@
// ----------------------------------------------------------------------------
// cfr_parser
// Frame parser: header hunt, payload capture, running sum, checksum compare.
// ----------------------------------------------------------------------------
`include "checksum_frame_receiver_defines.svh"

module cfr_parser
  import cfr_pkg::*;
#(
  parameter int FRAME_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] header_i,
  output commit_t    commit_o,
  output payload_t   pending_o
);

  localparam logic [POS_W-1:0] LastPos = POS_W'(FRAME_BYTES - 1);

  phase_e             phase_q, phase_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [7:0]         sum_q, sum_d;
  logic               pend_we;
  payload_t           pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    pend_we  = 1'b0;
    commit_o = '0;
    if (step_i && (command_i == CMD_BYTE)) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == header_i) begin
            phase_d = PH_PAYLOAD;
            pos_d   = '0;
            sum_d   = '0;
          end
        end
        PH_PAYLOAD: begin
          pend_we = 1'b1;
          sum_d   = sum_q + rx_byte_i;
          if (pos_q == LastPos) begin
            phase_d = PH_CHECK;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
        PH_CHECK: begin
          commit_o.ok  = (rx_byte_i == sum_q);
          commit_o.bad = (rx_byte_i != sum_q);
          phase_d      = PH_HUNT;
          pos_d        = '0;
          sum_d        = '0;
        end
        default: begin
          phase_d = PH_HUNT;
          pos_d   = '0;
          sum_d   = '0;
        end
      endcase
    end
  end

  // pending payload: written before read, no reset
  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_q[pos_q] <= rx_byte_i;
    end
  end

  assign pending_o = pend_q;

  `CFR_ASSERT(a_hunt_clean, (phase_q == PH_HUNT) |-> (pos_q == '0 && sum_q == '0),
              "parser: stale position or sum while hunting")
  `CFR_ASSERT(a_check_pos, (phase_q == PH_CHECK) |-> (pos_q == '0),
              "parser: position not cleared at checksum byte")
  `CFR_ASSERT(a_commit_src, (commit_o.ok || commit_o.bad) |->
              (phase_q == PH_CHECK && step_i && command_i == CMD_BYTE),
              "parser: frame status outside checksum byte")

endmodule

@@ rtl/cfr_holder.sv @@
// ----------------------------------------------------------------------------
// cfr_holder
// Held payload, valid flag and saturating age counter with timeout.
// ----------------------------------------------------------------------------
`include "checksum_frame_receiver_defines.svh"

module cfr_holder
  import cfr_pkg::*;
#(
  parameter int FRAME_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        command_i,
  input  commit_t     commit_i,
  input  payload_t    pending_i,
  input  logic [15:0] timeout_i,
  output payload_t    held_o,
  output logic        valid_o
);

  payload_t    held_q, held_d;
  logic        valid_q, valid_d;
  logic [15:0] age_q, age_d;
  logic        tick;

  assign tick = step_i && (command_i == CMD_TICK);

  always_comb begin
    held_d  = held_q;
    valid_d = valid_q;
    age_d   = age_q;
    if (tick) begin
      age_d = (age_q == AGE_MAX) ? age_q : age_q + 16'd1;
      if (age_d > timeout_i) begin
        held_d  = '0;
        valid_d = 1'b0;
      end
    end else if (step_i && commit_i.ok) begin
      // bytes beyond a short frame are never loaded
      for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
        if (i < FRAME_BYTES) begin
          held_d[i] = pending_i[i];
        end
      end
      valid_d = 1'b1;
      age_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      valid_q <= 1'b0;
      age_q   <= AGE_MAX;
    end else begin
      held_q  <= held_d;
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  assign held_o  = held_q;
  assign valid_o = valid_q;

  `CFR_ASSERT(a_stale_zero, !valid_q |-> (held_q == '0),
              "holder: stale payload not cleared")
  `CFR_ASSERT(a_good_frame, (step_i && command_i == CMD_BYTE && commit_i.ok) |=>
              (valid_q && age_q == '0), "holder: good frame not taken")
  `CFR_ASSERT(a_age_sat, (tick && age_q == AGE_MAX) |=> (age_q == AGE_MAX),
              "holder: age counter wrapped")

endmodule

@@ tb/checksum_frame_receiver_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checksum_frame_receiver_test
// Self-checking bench for the checksum frame receiver. Received bytes and
// millisecond ticks go in as random and directed streams of frames, noise and
// tick bursts. A scoreboard predicts the held data and the frame pulses for
// every input transaction and checks each result transaction in order. Both
// handshakes stall at random, and the run steps through several header and
// timeout settings.
// ----------------------------------------------------------------------------
module checksum_frame_receiver_test;
  import cfr_pkg::*;

  localparam int FRAME_BYTES = 4;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    payload_t data;
    logic     valid;
    logic     ok;
    logic     bad;
  } held_view_t;

  // Tracks the parser, the held payload and its age; queues the view that
  // each input transaction should produce.
  class held_data_checker;
    logic [7:0]  header_byte;
    logic [15:0] timeout_ticks;
    phase_e      phase;
    int          slot;
    logic [7:0]  sum;
    payload_t    pending;
    payload_t    held;
    logic        held_valid;
    logic [15:0] age;
    held_view_t  expected_q[$];
    int          mismatches;
    int          checked;
    int          good_frames;
    int          bad_frames;
    int          expiries;
    int          ticks;

    function new();
      header_byte   = HEADER_RESET;
      timeout_ticks = TIMEOUT_RESET;
      phase         = PH_HUNT;
      slot          = 0;
      sum           = '0;
      pending       = '0;
      held          = '0;
      held_valid    = 1'b0;
      age           = AGE_MAX;
      mismatches    = 0;
      checked       = 0;
      good_frames   = 0;
      bad_frames    = 0;
      expiries      = 0;
      ticks         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_HEADER) begin
        header_byte = value[7:0];
      end else if (idx == CFG_TIMEOUT) begin
        timeout_ticks = value;
      end
    endfunction

    function void note_item(logic cmd, logic [7:0] rx);
      held_view_t e;
      int         i;
      e.ok  = 1'b0;
      e.bad = 1'b0;
      if (cmd == CMD_TICK) begin
        ticks++;
        if (age != AGE_MAX) age = age + 16'd1;
        if (age > timeout_ticks) begin
          if (held_valid) expiries++;
          held       = '0;
          held_valid = 1'b0;
        end
      end else begin
        case (phase)
          PH_HUNT: begin
            if (rx == header_byte) begin
              phase = PH_PAYLOAD;
              slot  = 0;
              sum   = '0;
            end
          end
          PH_PAYLOAD: begin
            pending[slot] = rx;
            sum = sum + rx;
            if (slot + 1 >= FRAME_BYTES) begin
              phase = PH_CHECK;
              slot  = 0;
            end else begin
              slot++;
            end
          end
          default: begin
            if (rx == sum) begin
              for (i = 0; i < FRAME_BYTES; i++) held[i] = pending[i];
              held_valid = 1'b1;
              age        = '0;
              e.ok       = 1'b1;
              good_frames++;
            end else begin
              e.bad = 1'b1;
              bad_frames++;
            end
            phase = PH_HUNT;
            slot  = 0;
            sum   = '0;
          end
        endcase
      end
      e.data  = held;
      e.valid = held_valid;
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 20) $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_result(held_view_t got);
      held_view_t e;
      int         i;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
        return;
      end
      e = expected_q.pop_front();
      for (i = 0; i < MAX_FRAME_BYTES; i++) begin
        if (got.data[i] !== e.data[i]) begin
          report_mismatch($sformatf("data%0d got %02h, want %02h", i, got.data[i], e.data[i]));
        end
      end
      if (got.valid !== e.valid) begin
        report_mismatch($sformatf("data_valid got %b, want %b", got.valid, e.valid));
      end
      if (got.ok !== e.ok) begin
        report_mismatch($sformatf("frame_ok got %b, want %b", got.ok, e.ok));
      end
      if (got.bad !== e.bad) begin
        report_mismatch($sformatf("frame_bad got %b, want %b", got.bad, e.bad));
      end
    endtask
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_HEADER;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  command_i   = CMD_BYTE;
  logic [7:0]            rx_byte_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [7:0]            data0_o;
  logic [7:0]            data1_o;
  logic [7:0]            data2_o;
  logic [7:0]            data3_o;
  logic                  data_valid_o;
  logic                  frame_ok_o;
  logic                  frame_bad_o;

  held_data_checker chk;
  bit               quiet      = 1'b0;
  bit               hold_req   = 1'b0;
  int               items_sent = 0;
  int               settings   = 0;
  int               holds      = 0;

  checksum_frame_receiver #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data0_o     (data0_o),
    .data1_o     (data1_o),
    .data2_o     (data2_o),
    .data3_o     (data3_o),
    .data_valid_o(data_valid_o),
    .frame_ok_o  (frame_ok_o),
    .frame_bad_o (frame_bad_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Offers one transaction and returns right after the edge that takes it.
  task automatic send_item(logic cmd, logic [7:0] rx);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    rx_byte_i  <= rx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    chk.note_item(cmd, rx);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  function automatic payload_t random_payload();
    payload_t p;
    int       i;
    for (i = 0; i < MAX_FRAME_BYTES; i++) begin
      p[i] = ($urandom_range(0, 7) == 0) ? chk.header_byte : 8'($urandom_range(0, 255));
    end
    return p;
  endfunction

  task automatic send_frame(payload_t p, bit good_sum, int tick_pct);
    logic [7:0] s;
    int         i;
    s = '0;
    send_item(CMD_BYTE, chk.header_byte);
    for (i = 0; i < FRAME_BYTES; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      send_item(CMD_BYTE, p[i]);
      s = s + p[i];
    end
    if ($urandom_range(0, 99) < tick_pct) send_tick();
    send_item(CMD_BYTE, good_sum ? s : s ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic send_random_traffic(int n);
    int stop;
    int k;
    stop = items_sent + n;
    while (items_sent < stop) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        send_frame(random_payload(), $urandom_range(0, 4) != 0, 10);
      end else if (k < 85) begin
        repeat ($urandom_range(1, 20)) send_tick();
      end else if (k < 93) begin
        send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        // truncated frame: whatever follows is taken as payload
        send_item(CMD_BYTE, chk.header_byte);
        repeat ($urandom_range(0, 3)) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (chk.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [7:0] hdr, logic [15:0] tmo);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HEADER;
    cfg_wdata_i <= {8'h00, hdr};
    @(posedge clk_i);
    chk.write_reg(CFG_HEADER, {8'h00, hdr});
    cfg_idx_i   <= CFG_TIMEOUT;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    chk.write_reg(CFG_TIMEOUT, tmo);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // result side: checks, random stalls and the one long hold-off
  initial begin
    held_view_t got;
    int         stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = {data3_o, data2_o, data1_o, data0_o, data_valid_o, frame_ok_o, frame_bad_o};
        chk.check_result(got);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        holds++;
        stall = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(0, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    chk = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: tick while stale, noise, wrap-around sum
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, HEADER_RESET);
    repeat (4) send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'hFC);
    // header value as payload, tick mid-frame, header value as a wrong sum
    send_item(CMD_BYTE, HEADER_RESET);
    send_item(CMD_BYTE, HEADER_RESET);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_BYTE, 8'h12);
    send_item(CMD_BYTE, 8'h34);
    send_item(CMD_BYTE, HEADER_RESET);
    send_frame('0, 1'b1, 0);
    send_tick();

    drain_results();
    write_cfg(8'h00, 16'h0000);
    send_random_traffic(110);

    drain_results();
    write_cfg(8'hFF, 16'd3);
    send_random_traffic(60);
    drain_results();
    send_random_traffic(60);

    drain_results();
    write_cfg(8'($urandom_range(1, 254)), TIMEOUT_RESET);
    hold_req = 1'b1;
    send_random_traffic(110);

    // largest timeout: held data stays fresh through a tick burst
    drain_results();
    write_cfg(8'($urandom_range(1, 254)), AGE_MAX);
    send_random_traffic(80);
    send_frame(random_payload(), 1'b1, 0);
    repeat (16) send_tick();
    send_random_traffic(20);

    drain_results();
    quiet = 1'b1;
    write_cfg(8'($urandom_range(1, 254)), 16'($urandom_range(1, 40)));
    send_random_traffic(120);

    drain_results();
    repeat (4) @(posedge clk_i);

    $display("%0d input transactions, %0d results checked, %0d register settings, %0d hold-off",
             items_sent, chk.checked, settings, holds);
    $display("%0d good frames, %0d bad frames, %0d timeouts of held data, %0d ticks",
             chk.good_frames, chk.bad_frames, chk.expiries, chk.ticks);
    if (chk.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", chk.mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
